// ===== hdl/bmp_stream_decoder_macros.svh =====
// Assertion macros shared by the bitmap stream decoder RTL.
`ifndef BMP_STREAM_DECODER_MACROS_SVH
`define BMP_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BMP_SD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BMP_SD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bmp_sd_pkg.sv =====
// Types and constants shared by the bitmap stream decoder modules.
package bmp_sd_pkg;

  localparam int unsigned BMP_MAX_WIDTH  = 4096;
  localparam int unsigned BMP_MAX_HEIGHT = 4096;

  // Parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PIXELS = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_IDLE   = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_TYPE        = 4'd1;
  localparam logic [3:0] ERR_RESERVED    = 4'd2;
  localparam logic [3:0] ERR_INFO_SIZE   = 4'd3;
  localparam logic [3:0] ERR_WIDTH       = 4'd4;
  localparam logic [3:0] ERR_HEIGHT      = 4'd5;
  localparam logic [3:0] ERR_PLANES      = 4'd6;
  localparam logic [3:0] ERR_DEPTH       = 4'd7;
  localparam logic [3:0] ERR_COMPRESSION = 4'd8;
  localparam logic [3:0] ERR_OFFSET      = 4'd9;
  localparam logic [3:0] ERR_TOO_LARGE   = 4'd10;

  // Header byte positions on which a field completes
  localparam logic [5:0] HDR_TYPE_END     = 6'd1;
  localparam logic [5:0] HDR_RESERVED_END = 6'd9;
  localparam logic [5:0] HDR_OFFSET_END   = 6'd13;
  localparam logic [5:0] HDR_INFO_END     = 6'd17;
  localparam logic [5:0] HDR_WIDTH_END    = 6'd21;
  localparam logic [5:0] HDR_HEIGHT_END   = 6'd25;
  localparam logic [5:0] HDR_PLANES_END   = 6'd27;
  localparam logic [5:0] HDR_DEPTH_END    = 6'd29;
  localparam logic [5:0] HDR_COMPR_END    = 6'd33;
  localparam logic [5:0] HDR_LAST         = 6'd53;

  localparam logic [15:0] BMP_MAGIC     = 16'h4D42;  // 'B' then 'M'
  localparam logic [31:0] BMP_INFO_SIZE = 32'd40;
  localparam logic [31:0] BMP_HDR_BYTES = 32'd54;
  localparam logic [15:0] BMP_BPP_24    = 16'd24;
  localparam logic [15:0] BMP_BPP_32    = 16'd32;
  localparam logic [7:0]  BMP_OPAQUE    = 8'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  error_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } res_t;

endpackage

// ===== hdl/bmp_sd_parse.sv =====
// Header check, offset skip and pixel assembly for one file byte per cycle while step_en_i is high.
`include "bmp_stream_decoder_macros.svh"

module bmp_sd_parse #(
  parameter int unsigned MAX_WIDTH  = bmp_sd_pkg::BMP_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bmp_sd_pkg::BMP_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  bmp_sd_pkg::in_item_t item_i,
  output logic                 res_valid_o,
  output bmp_sd_pkg::res_t     res_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic [2:0]    phase_q, phase_d;
  logic [5:0]    pos_q, pos_d;
  logic [31:0]   shift_q, shift_d;
  logic [31:0]   offset_q, offset_d;
  logic [31:0]   skip_q, skip_d;
  logic [WW-1:0] width_q, width_d;
  logic          w_ovf_q, w_ovf_d;
  logic [HW-1:0] height_q, height_d;
  logic          h_ovf_q, h_ovf_d;
  logic          top_down_q, top_down_d;
  logic          four_q, four_d;
  logic [23:0]   pb_q, pb_d;
  logic [1:0]    bip_q, bip_d;
  logic [WW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [1:0]    pad_q, pad_d;

  logic [2:0]    cur_phase;
  logic [5:0]    cur_pos;
  logic [31:0]   cur_shift;
  logic [31:0]   v;
  logic [31:0]   h_abs;
  logic [7:0]    b;
  logic [23:0]   pb_base;
  logic [23:0]   pb_next;
  logic [23:0]   pix_bytes;
  logic [7:0]    pix_alpha;
  logic          pix_go;
  logic [WW:0]   col_inc;
  logic [HW:0]   row_inc;
  logic [HW-1:0] row_dst;
  logic          last;
  logic [31:0]   col_ext, row_ext, w_ext, h_ext;
  logic          emit;
  bmp_sd_pkg::res_t res;

  assign b         = item_i.data_byte;
  assign cur_phase = item_i.file_start ? bmp_sd_pkg::PH_HEADER : phase_q;
  assign cur_pos   = item_i.file_start ? 6'd0 : pos_q;
  assign cur_shift = item_i.file_start ? 32'd0 : shift_q;
  assign v         = {b, cur_shift[31:8]};
  assign h_abs     = v[31] ? (~v + 32'd1) : v;

  assign col_inc = {1'b0, col_q} + {{WW{1'b0}}, 1'b1};
  assign row_inc = {1'b0, row_q} + {{HW{1'b0}}, 1'b1};
  assign last    = (col_inc == {1'b0, width_q}) && (row_inc == {1'b0, height_q});
  assign row_dst = top_down_q ? row_q : (height_q - {{(HW-1){1'b0}}, 1'b1} - row_q);
  assign col_ext = 32'(col_q);
  assign row_ext = 32'(row_dst);
  assign w_ext   = 32'(width_q);
  assign h_ext   = 32'(height_q);

  // Byte lanes of the pixel: B at 0, G at 1, R at 2; a new pixel starts clear.
  always_comb begin
    pb_base = (bip_q == 2'd0) ? 24'd0 : pb_q;
    pb_next = pb_base;
    unique case (bip_q)
      2'd0:    pb_next[7:0]   = b;
      2'd1:    pb_next[15:8]  = b;
      2'd2:    pb_next[23:16] = b;
      default: pb_next        = pb_base;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    shift_d    = shift_q;
    offset_d   = offset_q;
    skip_d     = skip_q;
    width_d    = width_q;
    w_ovf_d    = w_ovf_q;
    height_d   = height_q;
    h_ovf_d    = h_ovf_q;
    top_down_d = top_down_q;
    four_d     = four_q;
    pb_d       = pb_q;
    bip_d      = bip_q;
    col_d      = col_q;
    row_d      = row_q;
    pad_d      = pad_q;
    emit       = 1'b0;
    res        = '0;
    pix_bytes  = pb_q;
    pix_alpha  = b;
    pix_go     = 1'b0;

    if (step_en_i) begin
      phase_d = cur_phase;
      unique case (cur_phase)
        bmp_sd_pkg::PH_HEADER: begin
          shift_d = v;
          pos_d   = cur_pos + 6'd1;
          case (cur_pos)
            bmp_sd_pkg::HDR_TYPE_END: begin
              if (v[31:16] != bmp_sd_pkg::BMP_MAGIC) begin
                emit = 1'b1;
                res.error_code = bmp_sd_pkg::ERR_TYPE;
              end
            end
            bmp_sd_pkg::HDR_RESERVED_END: begin
              if (v != 32'd0) begin
                emit = 1'b1;
                res.error_code = bmp_sd_pkg::ERR_RESERVED;
              end
            end
            bmp_sd_pkg::HDR_OFFSET_END: offset_d = v;
            bmp_sd_pkg::HDR_INFO_END: begin
              if (v != bmp_sd_pkg::BMP_INFO_SIZE) begin
                emit = 1'b1;
                res.error_code = bmp_sd_pkg::ERR_INFO_SIZE;
              end
            end
            bmp_sd_pkg::HDR_WIDTH_END: begin
              if (v == 32'd0 || v[31]) begin
                emit = 1'b1;
                res.error_code = bmp_sd_pkg::ERR_WIDTH;
              end else begin
                width_d = v[WW-1:0];
                w_ovf_d = v > 32'(MAX_WIDTH);
              end
            end
            bmp_sd_pkg::HDR_HEIGHT_END: begin
              if (v == 32'd0) begin
                emit = 1'b1;
                res.error_code = bmp_sd_pkg::ERR_HEIGHT;
              end else begin
                top_down_d = v[31];
                height_d   = h_abs[HW-1:0];
                h_ovf_d    = h_abs > 32'(MAX_HEIGHT);
              end
            end
            bmp_sd_pkg::HDR_PLANES_END: begin
              if (v[31:16] != 16'd1) begin
                emit = 1'b1;
                res.error_code = bmp_sd_pkg::ERR_PLANES;
              end
            end
            bmp_sd_pkg::HDR_DEPTH_END: begin
              if (v[31:16] != bmp_sd_pkg::BMP_BPP_24 && v[31:16] != bmp_sd_pkg::BMP_BPP_32) begin
                emit = 1'b1;
                res.error_code = bmp_sd_pkg::ERR_DEPTH;
              end else begin
                four_d = (v[31:16] == bmp_sd_pkg::BMP_BPP_32);
              end
            end
            bmp_sd_pkg::HDR_COMPR_END: begin
              if (v != 32'd0) begin
                emit = 1'b1;
                res.error_code = bmp_sd_pkg::ERR_COMPRESSION;
              end
            end
            bmp_sd_pkg::HDR_LAST: begin
              emit = 1'b1;
              if (offset_q < bmp_sd_pkg::BMP_HDR_BYTES) begin
                res.error_code = bmp_sd_pkg::ERR_OFFSET;
              end else if (w_ovf_q || h_ovf_q) begin
                res.error_code = bmp_sd_pkg::ERR_TOO_LARGE;
              end else begin
                res.kind         = bmp_sd_pkg::KIND_HEADER;
                res.image_width  = w_ext[12:0];
                res.image_height = h_ext[12:0];
                skip_d = offset_q - bmp_sd_pkg::BMP_HDR_BYTES;
                if (offset_q != bmp_sd_pkg::BMP_HDR_BYTES) begin
                  phase_d = bmp_sd_pkg::PH_SKIP;
                end else begin
                  phase_d = bmp_sd_pkg::PH_PIXELS;
                  bip_d   = 2'd0;
                  pb_d    = 24'd0;
                  col_d   = '0;
                  row_d   = '0;
                end
              end
            end
            default: ;
          endcase
          // Any failed check ends the file.
          if (emit && res.kind != bmp_sd_pkg::KIND_HEADER) begin
            res.kind = bmp_sd_pkg::KIND_ERROR;
            phase_d  = bmp_sd_pkg::PH_IDLE;
          end
        end
        bmp_sd_pkg::PH_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_q == 32'd1) begin
            phase_d = bmp_sd_pkg::PH_PIXELS;
            bip_d   = 2'd0;
            pb_d    = 24'd0;
            col_d   = '0;
            row_d   = '0;
          end
        end
        bmp_sd_pkg::PH_PIXELS: begin
          if (bip_q != 2'd3) begin
            pix_bytes = pb_next;
            pix_alpha = bmp_sd_pkg::BMP_OPAQUE;
            if (bip_q != 2'd2 || four_q) begin
              pb_d  = pb_next;
              bip_d = bip_q + 2'd1;
            end else begin
              pix_go = 1'b1;
            end
          end else begin
            pix_go = 1'b1;
          end
          if (pix_go) begin
            emit           = 1'b1;
            bip_d          = 2'd0;
            res.kind       = bmp_sd_pkg::KIND_PIXEL;
            res.red        = pix_bytes[23:16];
            res.green      = pix_bytes[15:8];
            res.blue       = pix_bytes[7:0];
            res.alpha      = pix_alpha;
            res.column     = col_ext[11:0];
            res.row        = row_ext[11:0];
            res.last_pixel = last;
            col_d          = col_inc[WW-1:0];
            if (col_inc >= {1'b0, width_q}) begin
              col_d = '0;
              row_d = row_inc[HW-1:0];
              if (last || row_inc >= {1'b0, height_q}) begin
                phase_d = bmp_sd_pkg::PH_IDLE;
              end else if (!four_q && w_ext[1:0] != 2'd0) begin
                pad_d   = w_ext[1:0];
                phase_d = bmp_sd_pkg::PH_PAD;
              end
            end
          end
        end
        bmp_sd_pkg::PH_PAD: begin
          pad_d = pad_q - 2'd1;
          if (pad_q == 2'd1) begin
            phase_d = bmp_sd_pkg::PH_PIXELS;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= bmp_sd_pkg::PH_HEADER;
      pos_q      <= '0;
      shift_q    <= '0;
      offset_q   <= '0;
      skip_q     <= '0;
      width_q    <= '0;
      w_ovf_q    <= 1'b0;
      height_q   <= '0;
      h_ovf_q    <= 1'b0;
      top_down_q <= 1'b0;
      four_q     <= 1'b0;
      pb_q       <= '0;
      bip_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      pad_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      shift_q    <= shift_d;
      offset_q   <= offset_d;
      skip_q     <= skip_d;
      width_q    <= width_d;
      w_ovf_q    <= w_ovf_d;
      height_q   <= height_d;
      h_ovf_q    <= h_ovf_d;
      top_down_q <= top_down_d;
      four_q     <= four_d;
      pb_q       <= pb_d;
      bip_q      <= bip_d;
      col_q      <= col_d;
      row_q      <= row_d;
      pad_q      <= pad_d;
    end
  end

  assign res_valid_o = emit;
  assign res_o       = res;

  `BMP_SD_ASSERT_NOW(a_hdr_on_last_byte, clk_i, rst_ni,
    emit && res.kind == bmp_sd_pkg::KIND_HEADER, cur_pos == bmp_sd_pkg::HDR_LAST,
    "header result away from the final header byte")
  `BMP_SD_ASSERT_NOW(a_pixel_in_row, clk_i, rst_ni,
    emit && res.kind == bmp_sd_pkg::KIND_PIXEL, col_q < width_q && row_q < height_q,
    "pixel position outside the accepted image")
  `BMP_SD_ASSERT_NEXT(a_idle_holds, clk_i, rst_ni,
    phase_q == bmp_sd_pkg::PH_IDLE && !(step_en_i && item_i.file_start),
    phase_q == bmp_sd_pkg::PH_IDLE, "parser left idle without a file start")
  `BMP_SD_ASSERT_NOW(a_pad_only_24bpp, clk_i, rst_ni,
    phase_q == bmp_sd_pkg::PH_PAD, !four_q && pad_q != 2'd0,
    "row padding outside a 24-bit image")

endmodule

// ===== hdl/bmp_sd_outreg.sv =====
// Result register between the parser and the output stream.
module bmp_sd_outreg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  bmp_sd_pkg::res_t in_res_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bmp_sd_pkg::res_t out_res_o
);

  logic             valid_q;
  bmp_sd_pkg::res_t res_q;

  // Advance whenever the held result is gone or leaves this cycle.
  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && in_valid_i) begin
      res_q <= in_res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== hdl/bmp_stream_decoder.sv =====
// Streaming decoder for uncompressed 24/32-bit bitmap files, one file byte per transfer.
// Feed the file one byte per transfer with s_axis_tuser set on its first byte; that
// restarts the parse at any point, and after an error or the final pixel all bytes are
// dropped until the next marked byte. The 54-byte header is checked field by field and
// either an error or a header result (width, absolute height) comes out; then the
// bytes up to the pixel offset and the row padding of 24-bit images are skipped and
// each complete pixel comes out as RGBA with its column and top-first row. One byte is
// taken every cycle while the output keeps up: an input register and a result register
// bracket the combinational parse logic, so a result comes from the result register once
// the parse of its last byte from the input register is taken in, and the input stalls
// only when the result register is full and held.
module bmp_stream_decoder #(
  parameter int unsigned MAX_WIDTH  = bmp_sd_pkg::BMP_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bmp_sd_pkg::BMP_MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] file_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [3:0] error_code, [11:4] red, [19:12] green,
                                      // [27:20] blue, [35:28] alpha, [47:36] column,
                                      // [59:48] row, [72:60] image_width,
                                      // [85:73] image_height, [87:86] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_pixel
);

  logic                 in_valid_q;
  bmp_sd_pkg::in_item_t in_item_q;
  logic                 advance;
  logic                 step_en;
  logic                 res_valid;
  bmp_sd_pkg::res_t     res;
  bmp_sd_pkg::res_t     out_res;

  assign s_axis_tready = !in_valid_q || advance;
  assign step_en       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.data_byte  <= s_axis_tdata;
      in_item_q.file_start <= s_axis_tuser[0];
    end
  end

  bmp_sd_parse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bmp_sd_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (step_en && res_valid),
    .in_res_i    (res),
    .ready_o     (advance),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res.image_height, out_res.image_width, out_res.row,
                         out_res.column, out_res.alpha, out_res.blue, out_res.green,
                         out_res.red, out_res.error_code};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last_pixel;

endmodule
